// File: design/profile_log_odds_dot_score_macros.svh
// Assertion macros for the profile log-odds scorer
`ifndef PROFILE_LOG_ODDS_DOT_SCORE_MACROS_SVH
`define PROFILE_LOG_ODDS_DOT_SCORE_MACROS_SVH
`ifndef SYNTHESIS
`define PLS_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PLS_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define PLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// File: design/pls_pkg.sv
package pls_pkg;
    typedef enum logic [1:0] {
        REQ_BG    = 2'd0,
        REQ_SCORE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam int CFG_LENGTH_A = 0;
    localparam int CFG_LENGTH_B = 1;

    localparam int FREQ_W   = 16;
    localparam int BG_W     = 28;
    localparam int LEN_W    = 13;
    localparam int SYM_W    = 5;
    localparam int LOG_FRAC = 20;
    localparam int LOG_W    = 26;   // msb position (<64) plus 20 fraction bits
    localparam logic [BG_W-1:0] BG_SUM_MAX = {BG_W{1'b1}};
    localparam logic [15:0] EPS_Q32 = 16'd42950;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // work item passed from front to back
    typedef struct packed {
        logic                is_score;   // else: pass-through of last only
        logic                valid_sym;
        logic                last;
        logic [FREQ_W-1:0]   freq_a;
        logic [FREQ_W-1:0]   freq_b;
        logic [BG_W-1:0]     sum_a;
        logic [BG_W-1:0]     sum_b;
    } work_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_NORM,
        B_LOG,
        B_LNMUL,
        B_LNRND,
        B_NEXTOP,
        B_PROD,
        B_ACC,
        B_OUT
    } bstate_t;
endpackage

// File: design/profile_log_odds_dot_score.sv
// Profile-profile log-odds dot-product scorer.
// Input channel s_*: valid/ready items. req_type 0 adds bg_freq into the
// background sum of profile A or B for one symbol, 2 clears all sums,
// 1 scores one symbol; last=1 closes a run and yields one result on m_*.
// Config: cfg_we/cfg_index/cfg_data write length_a (0) and length_b (1).
// Background and clear items finish in the cycle they are accepted.
// Score items enter a two-entry queue; the back end works one at a time:
// after the pop, for each profile a restoring divide (bg mean), then two
// passes of normalize plus squaring log2 (frequency, then mean) and the
// ln/round steps, then product and accumulate. An item with an out-of-range
// symbol skips all of this. A last item then goes through B_OUT,
// which loads the output register; m_valid rises the cycle after that.
// Results sit in an output register; while m_ready is low the back end
// holds off, the queue fills and then s_ready drops.
// Reset (synchronous, aresetn low) clears the sums, accumulator, flag and
// length registers to 1.
`include "profile_log_odds_dot_score_macros.svh"
module profile_log_odds_dot_score
    import pls_pkg::*;
#(
    parameter int NUM_SYMBOLS     = 20,
    parameter int MAX_PROFILE_LEN = 4096,
    parameter int FREQ_FRAC_BITS  = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [LEN_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic               s_profile_sel,
    input  logic [SYM_W-1:0]   s_symbol,
    input  logic [FREQ_W-1:0]  s_bg_freq,
    input  logic [FREQ_W-1:0]  s_freq_a,
    input  logic [FREQ_W-1:0]  s_freq_b,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_score,
    output logic               m_saturated
);
    logic [LEN_W-1:0] length_a_reg, length_b_reg;
    logic  q_push, q_full, q_pop, q_nonempty;
    work_t q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_a_reg <= LEN_W'(1);
            length_b_reg <= LEN_W'(1);
        end else if (cfg_we) begin
            if (cfg_index == 1'(CFG_LENGTH_A)) length_a_reg <= cfg_data;
            else                               length_b_reg <= cfg_data;
        end
    end

    pls_front #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_profile_sel,
        .s_symbol, .s_bg_freq, .s_freq_a, .s_freq_b, .s_last,
        .q_push, .q_data(q_in), .q_full
    );

    pls_queue u_queue (
        .aclk, .aresetn, .push(q_push), .din(q_in), .full(q_full),
        .pop(q_pop), .dout(q_out), .nonempty(q_nonempty)
    );

    pls_back #(.MAX_PROFILE_LEN(MAX_PROFILE_LEN), .FREQ_FRAC_BITS(FREQ_FRAC_BITS)) u_back (
        .aclk, .aresetn, .length_a(length_a_reg), .length_b(length_b_reg),
        .q_nonempty, .q_data(q_out), .q_pop, .m_valid, .m_ready, .m_score, .m_saturated
    );

    `PLS_ASSERT_IMPL(a_no_push_full, aclk, aresetn, !(q_push && q_full), "push into full queue")
    `PLS_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, !(q_pop && !q_nonempty), "pop from empty queue")
    `PLS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_score), "result dropped")
endmodule

// File: design/pls_front.sv
module pls_front
    import pls_pkg::*;
#(
    parameter int NUM_SYMBOLS = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic              s_profile_sel,
    input  logic [SYM_W-1:0]  s_symbol,
    input  logic [FREQ_W-1:0] s_bg_freq,
    input  logic [FREQ_W-1:0] s_freq_a,
    input  logic [FREQ_W-1:0] s_freq_b,
    input  logic              s_last,
    output logic              q_push,
    output work_t             q_data,
    input  logic              q_full
);
    logic [BG_W-1:0] sum_a_reg [NUM_SYMBOLS];
    logic [BG_W-1:0] sum_b_reg [NUM_SYMBOLS];
    logic            acc;
    logic            sym_ok;
    logic [BG_W:0]   add_v;
    logic [BG_W-1:0] cur;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;
    assign sym_ok  = {27'd0, s_symbol} < NUM_SYMBOLS;
    assign cur     = sym_ok ? (s_profile_sel ? sum_b_reg[s_symbol] : sum_a_reg[s_symbol])
                            : '0;
    assign add_v   = {1'b0, cur} + {13'd0, s_bg_freq};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                sum_a_reg[i] <= '0;
                sum_b_reg[i] <= '0;
            end
        end else if (acc) begin
            if (req_t'(s_req_type) == REQ_CLEAR) begin
                for (int i = 0; i < NUM_SYMBOLS; i++) begin
                    sum_a_reg[i] <= '0;
                    sum_b_reg[i] <= '0;
                end
            end else if (req_t'(s_req_type) == REQ_BG && sym_ok) begin
                if (s_profile_sel) begin
                    sum_b_reg[s_symbol] <= add_v[BG_W] ? BG_SUM_MAX : add_v[BG_W-1:0];
                end else begin
                    sum_a_reg[s_symbol] <= add_v[BG_W] ? BG_SUM_MAX : add_v[BG_W-1:0];
                end
            end
        end
    end

    always_comb begin
        q_push           = acc && (req_t'(s_req_type) == REQ_SCORE);
        q_data.is_score  = 1'b1;
        q_data.valid_sym = sym_ok;
        q_data.last      = s_last;
        q_data.freq_a    = s_freq_a;
        q_data.freq_b    = s_freq_b;
        q_data.sum_a     = sym_ok ? sum_a_reg[s_symbol] : '0;
        q_data.sum_b     = sym_ok ? sum_b_reg[s_symbol] : '0;
    end
endmodule

// File: design/pls_queue.sv
module pls_queue
    import pls_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  work_t din,
    output logic  full,
    input  logic  pop,
    output work_t dout,
    output logic  nonempty
);
    work_t       mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign nonempty = cnt_reg != 2'd0;
    assign dout     = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: design/pls_back.sv
module pls_back
    import pls_pkg::*;
#(
    parameter int MAX_PROFILE_LEN = 4096,
    parameter int FREQ_FRAC_BITS  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [LEN_W-1:0]  length_a,
    input  logic [LEN_W-1:0]  length_b,
    input  logic              q_nonempty,
    input  work_t             q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [31:0] m_score,
    output logic              m_saturated
);
    localparam int SH = 32 - FREQ_FRAC_BITS;
    localparam int NW = BG_W + SH + 6;   // numerator/quotient width

    bstate_t          state_reg, state_next;
    work_t            w_reg;
    logic             op_reg;          // 0: profile A, 1: profile B
    logic [5:0]       cnt_reg;
    logic [NW-1:0]    rem_reg, quo_reg;
    logic [LEN_W-1:0] len_reg;
    logic             phase_reg;       // 0: log of num, 1: log of den
    logic [32:0]      m_reg;
    logic [LOG_W-1:0] r_reg, lnum_reg;
    logic [47:0]      ad_reg;          // |d| staged for the ln2 multiply
    logic             dneg_reg;
    logic [63:0]      lnprod_reg;
    logic signed [31:0] la_reg, lb_reg;
    logic [63:0]      pm_reg;
    logic             pneg_reg;
    logic signed [31:0] acc_reg;
    logic             clip_reg;
    logic signed [31:0] out_score_reg;
    logic             out_sat_reg;
    logic             out_valid_reg;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] len_raw;
    logic [NW-1:0]    num_full;
    logic [NW:0]      trial;
    logic [NW-1:0]    log_in;
    logic [5:0]       msb;
    logic [32:0]      norm;
    logic [65:0]      sq;
    logic signed [LOG_W:0] dval;
    logic [31:0]      absa, absb;
    logic signed [32:0] sum_ext;

    always_comb begin
        len_raw = op_reg ? length_b : length_a;
        eff_len = len_raw;
        if (len_raw == '0) eff_len = {{(LEN_W-1){1'b0}}, 1'b1};
        if ({19'd0, len_raw} > MAX_PROFILE_LEN) eff_len = LEN_W'(MAX_PROFILE_LEN);
    end

    // restoring divider, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[NW-1]} - {{(NW-LEN_W+1){1'b0}}, len_reg};

    // value whose log is taken
    always_comb begin
        if (!phase_reg) begin
            log_in = (NW'(op_reg ? w_reg.freq_b : w_reg.freq_a) << SH) + NW'(EPS_Q32);
        end else begin
            log_in = quo_reg + NW'(EPS_Q32);
        end
        msb = '0;
        for (int i = 0; i < NW; i++) if (log_in[i]) msb = 6'(i);
        if (msb >= 6'd31) norm = 33'(log_in >> (msb - 6'd31));
        else              norm = 33'(log_in << (6'd31 - msb));
    end

    assign sq   = {33'd0, m_reg} * {33'd0, m_reg};
    assign dval = $signed({1'b0, lnum_reg}) - $signed({1'b0, r_reg});
    assign absa = la_reg[31] ? 32'(-la_reg) : la_reg;
    assign absb = lb_reg[31] ? 32'(-lb_reg) : lb_reg;
    assign sum_ext = {acc_reg[31], acc_reg} +
                     (pneg_reg ? -$signed({1'b0, pm_reg[31:0]}) : $signed({1'b0, pm_reg[31:0]}));

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            B_IDLE:   if (q_nonempty && !out_valid_reg) begin
                q_pop = 1'b1;
                state_next = (q_data.valid_sym) ? B_DIV : (q_data.last ? B_OUT : B_IDLE);
            end
            B_DIV:    if (cnt_reg == 6'(NW - 1)) state_next = B_NORM;
            B_NORM:   state_next = B_LOG;
            B_LOG:    if (cnt_reg == 6'(LOG_FRAC - 1)) state_next = phase_reg ? B_LNMUL : B_NORM;
            B_LNMUL:  state_next = B_LNRND;
            B_LNRND:  state_next = B_NEXTOP;
            B_NEXTOP: state_next = op_reg ? B_PROD : B_DIV;
            B_PROD:   state_next = B_ACC;
            B_ACC:    state_next = w_reg.last ? B_OUT : B_IDLE;
            B_OUT:    if (!out_valid_reg) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= B_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg        <= 1'b0;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE: if (q_pop) begin
                    w_reg   <= q_data;
                    op_reg  <= 1'b0;
                    cnt_reg <= '0;
                    rem_reg <= '0;
                    quo_reg <= NW'(q_data.sum_a) << SH;
                    len_reg <= length_a;
                end
                B_DIV: begin
                    if (cnt_reg == 6'd0) len_reg <= eff_len;
                    if (cnt_reg == 6'd0) begin
                        // first step uses the effective length
                        if ({rem_reg, quo_reg[NW-1]} >= {{(NW-LEN_W+1){1'b0}}, eff_len}) begin
                            rem_reg <= NW'({rem_reg, quo_reg[NW-1]} -
                                           {{(NW-LEN_W+1){1'b0}}, eff_len});
                            quo_reg <= {quo_reg[NW-2:0], 1'b1};
                        end else begin
                            rem_reg <= NW'({rem_reg, quo_reg[NW-1]});
                            quo_reg <= {quo_reg[NW-2:0], 1'b0};
                        end
                    end else if (!trial[NW]) begin
                        rem_reg <= trial[NW-1:0];
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_reg <= NW'({rem_reg, quo_reg[NW-1]});
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    cnt_reg <= (cnt_reg == 6'(NW - 1)) ? '0 : cnt_reg + 6'd1;
                    phase_reg <= 1'b0;
                end
                B_NORM: begin
                    m_reg   <= norm;
                    r_reg   <= LOG_W'({msb, 20'd0});
                    cnt_reg <= '0;
                end
                B_LOG: begin
                    if (sq[65:31] >= 35'h100000000) begin
                        m_reg <= 33'(sq[65:32]);
                        r_reg[LOG_FRAC-1-cnt_reg[4:0]] <= 1'b1;
                    end else begin
                        m_reg <= sq[63:31];
                    end
                    cnt_reg <= (cnt_reg == 6'(LOG_FRAC - 1)) ? '0 : cnt_reg + 6'd1;
                    if (cnt_reg == 6'(LOG_FRAC - 1) && !phase_reg) begin
                        phase_reg <= 1'b1;
                        lnum_reg  <= (sq[65:31] >= 35'h100000000) ?
                                     (r_reg | LOG_W'(1 << (LOG_FRAC - 1 - cnt_reg[4:0]))) : r_reg;
                    end
                end
                B_LNMUL: begin
                    dneg_reg   <= dval[LOG_W];
                    ad_reg     <= 48'(dval[LOG_W] ? -dval : dval);
                end
                B_LNRND: begin
                    lnprod_reg <= 64'(ad_reg[31:0]) * 64'(LN2_Q32);
                end
                B_NEXTOP: begin
                    // (|d|*ln2 + 2^35) >> 36
                    if (!op_reg) begin
                        la_reg <= dneg_reg ? -32'((lnprod_reg + 64'h800000000) >> 36)
                                           :  32'((lnprod_reg + 64'h800000000) >> 36);
                        op_reg  <= 1'b1;
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= NW'(w_reg.sum_b) << SH;
                        len_reg <= length_b;
                    end else begin
                        lb_reg <= dneg_reg ? -32'((lnprod_reg + 64'h800000000) >> 36)
                                           :  32'((lnprod_reg + 64'h800000000) >> 36);
                    end
                end
                B_PROD: begin
                    pm_reg   <= (64'(absa) * 64'(absb) + 64'h8000) >> 16;
                    pneg_reg <= la_reg[31] ^ lb_reg[31];
                end
                B_ACC: begin
                    if (sum_ext > 33'sh07FFFFFFF) begin
                        acc_reg <= 32'h7FFFFFFF; clip_reg <= 1'b1;
                    end else if (sum_ext < -33'sh080000000) begin
                        acc_reg <= 32'h80000000; clip_reg <= 1'b1;
                    end else begin
                        acc_reg <= sum_ext[31:0];
                    end
                end
                B_OUT: if (!out_valid_reg) begin
                    out_score_reg <= acc_reg;
                    out_sat_reg   <= clip_reg;
                    out_valid_reg <= 1'b1;
                    acc_reg       <= '0;
                    clip_reg      <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_score     = out_score_reg;
    assign m_saturated = out_sat_reg;
endmodule
